// File: src/tspm_pkg.sv
// ----------------------------------------------------------------------------
// tspm_pkg
// Shared types and codes of the timer slot pool manager.
// ----------------------------------------------------------------------------
package tspm_pkg;

  localparam int DEF_NUM_SLOTS = 64;
  localparam int SEL_W         = 6;

  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_STOP    = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_IGNORED = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic        in_use;
    logic        periodic;
    logic [15:0] owner;
    logic [31:0] label;
    logic [31:0] word;
  } slot_rec_t;

  typedef struct packed {
    logic rd_en;
    logic pop;
    logic push;
    logic clear;
  } fl_ctrl_t;

endpackage

// File: src/tspm_ram.sv
// ----------------------------------------------------------------------------
// tspm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tspm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/tspm_free_list.sv
// ----------------------------------------------------------------------------
// tspm_free_list
// FIFO free list: head, tail and count registers over a link RAM.
// ----------------------------------------------------------------------------
module tspm_free_list #(
  parameter int NUM_SLOTS = tspm_pkg::DEF_NUM_SLOTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tspm_pkg::fl_ctrl_t           ctrl,
  input  logic [$clog2(NUM_SLOTS)-1:0] push_id,
  input  logic [$clog2(NUM_SLOTS)-1:0] clear_addr,
  output logic [$clog2(NUM_SLOTS)-1:0] head,
  output logic                         empty
);

  localparam int ID_W = $clog2(NUM_SLOTS);
  localparam int CW   = $clog2(NUM_SLOTS + 1);

  logic [ID_W-1:0] tail;
  logic [CW-1:0]   count;
  logic [ID_W-1:0] head_next;
  logic [ID_W-1:0] tail_next;
  logic [CW-1:0]   count_next;
  logic            link_we;
  logic [ID_W-1:0] link_waddr;
  logic [ID_W-1:0] link_wdata;
  logic [ID_W-1:0] link_rdata;

  assign empty = (count == '0);

  tspm_ram #(
    .WIDTH(ID_W),
    .DEPTH(NUM_SLOTS)
  ) u_link_ram (
    .clk  (clk),
    .we   (link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .re   (ctrl.rd_en),
    .raddr(head),
    .rdata(link_rdata)
  );

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    link_we    = 1'b0;
    link_waddr = tail;
    link_wdata = push_id;
    if (ctrl.clear) begin
      link_we    = 1'b1;
      link_waddr = clear_addr;
      link_wdata = clear_addr + ID_W'(1);
    end else if (ctrl.pop) begin
      count_next = count - CW'(1);
      if (count != CW'(1)) begin
        head_next = link_rdata;
      end
    end else if (ctrl.push) begin
      if (count == '0) begin
        head_next = push_id;
      end else begin
        link_we = 1'b1;
      end
      tail_next  = push_id;
      count_next = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= ID_W'(NUM_SLOTS - 1);
      count <= CW'(NUM_SLOTS);
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

endmodule

// File: src/timer_slot_pool_manager.sv
// ----------------------------------------------------------------------------
// timer_slot_pool_manager
// Timer slot allocator with a FIFO free list and a per-slot record memory.
// ----------------------------------------------------------------------------
// Each request passes S_IDLE, where the beat is accepted while the slot record
// and the free-list link are read, then S_EXEC, where the result is built and
// the record, link and head/tail/count are written back. The single read of
// the slot memory followed by its write-back sets this split. After reset a
// clearing pass over all NUM_SLOTS entries initializes both memories, during
// which no request is accepted. A result waits in the output register; the next
// request is taken meanwhile and completes once that register is free.
module timer_slot_pool_manager #(
  parameter int NUM_SLOTS = tspm_pkg::DEF_NUM_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [15:0] owner_module,
  input  logic [31:0] timer_label,
  input  logic [31:0] duration,
  input  logic [31:0] user_word,
  input  logic        is_periodic,
  input  logic [5:0]  slot_sel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [5:0]  slot_out,
  output logic [31:0] period_out,
  output logic        msg_valid,
  output logic [15:0] msg_dest,
  output logic [31:0] msg_label,
  output logic [31:0] msg_word,
  output logic        slot_freed
);

  localparam int ID_W  = $clog2(NUM_SLOTS);
  localparam int AW    = ((ID_W > tspm_pkg::SEL_W) ? ID_W : tspm_pkg::SEL_W) + 1;
  localparam int REC_W = $bits(tspm_pkg::slot_rec_t);

  tspm_pkg::state_t state;
  tspm_pkg::state_t state_next;

  logic [ID_W-1:0]  clear_ptr;
  logic [1:0]       req_q;
  logic [15:0]      owner_q;
  logic [31:0]      label_q;
  logic [31:0]      duration_q;
  logic [31:0]      word_q;
  logic             periodic_q;
  logic [5:0]       sel_q;

  logic             accept;
  logic             go;
  logic [AW-1:0]    sel_in_wide;
  logic [AW-1:0]    sel_wide;
  logic [AW-1:0]    head_wide;
  logic             sel_ok;

  tspm_pkg::fl_ctrl_t fl_ctrl;
  logic [ID_W-1:0]  fl_head;
  logic             fl_empty;

  tspm_pkg::slot_rec_t rec_rd;
  tspm_pkg::slot_rec_t rec_wr;
  logic [REC_W-1:0] rec_rdata;
  logic             rec_we;
  logic [ID_W-1:0]  rec_waddr;
  logic [ID_W-1:0]  rec_raddr;

  logic [1:0]       status_next;
  logic [5:0]       slot_out_next;
  logic [31:0]      period_next;
  logic             msg_valid_next;
  logic [15:0]      msg_dest_next;
  logic [31:0]      msg_label_next;
  logic [31:0]      msg_word_next;
  logic             freed_next;

  assign accept      = in_valid && in_ready;
  assign go          = (state == tspm_pkg::S_EXEC) && (!out_valid || out_ready);
  assign sel_in_wide = AW'(slot_sel);
  assign sel_wide    = AW'(sel_q);
  assign head_wide   = AW'(fl_head);
  assign rec_raddr   = sel_in_wide[ID_W-1:0];
  assign rec_rd      = tspm_pkg::slot_rec_t'(rec_rdata);
  assign sel_ok      = (sel_wide < AW'(NUM_SLOTS)) && rec_rd.in_use;

  tspm_ram #(
    .WIDTH(REC_W),
    .DEPTH(NUM_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (rec_we),
    .waddr(rec_waddr),
    .wdata(rec_wr),
    .re   (accept),
    .raddr(rec_raddr),
    .rdata(rec_rdata)
  );

  tspm_free_list #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_free_list (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (fl_ctrl),
    .push_id   (sel_wide[ID_W-1:0]),
    .clear_addr(clear_ptr),
    .head      (fl_head),
    .empty     (fl_empty)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      tspm_pkg::S_CLEAR: begin
        if (clear_ptr == ID_W'(NUM_SLOTS - 1)) begin
          state_next = tspm_pkg::S_IDLE;
        end
      end
      tspm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = tspm_pkg::S_EXEC;
        end
      end
      tspm_pkg::S_EXEC: begin
        if (go) begin
          state_next = tspm_pkg::S_IDLE;
        end
      end
      default: state_next = tspm_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready       = (state == tspm_pkg::S_IDLE);
    fl_ctrl        = '0;
    fl_ctrl.rd_en  = accept;
    fl_ctrl.clear  = (state == tspm_pkg::S_CLEAR);
    rec_we         = (state == tspm_pkg::S_CLEAR);
    rec_waddr      = clear_ptr;
    rec_wr         = '0;
    status_next    = tspm_pkg::STAT_IGNORED;
    slot_out_next  = '0;
    period_next    = '0;
    msg_valid_next = 1'b0;
    msg_dest_next  = '0;
    msg_label_next = '0;
    msg_word_next  = '0;
    freed_next     = 1'b0;
    if (state == tspm_pkg::S_EXEC) begin
      unique case (req_q)
        tspm_pkg::REQ_START: begin
          if (fl_empty) begin
            status_next = tspm_pkg::STAT_EMPTY;
          end else begin
            status_next     = tspm_pkg::STAT_DONE;
            slot_out_next   = head_wide[5:0];
            period_next     = periodic_q ? duration_q : '0;
            fl_ctrl.pop     = go;
            rec_we          = go;
            rec_waddr       = fl_head;
            rec_wr.in_use   = 1'b1;
            rec_wr.periodic = periodic_q;
            rec_wr.owner    = owner_q;
            rec_wr.label    = label_q;
            rec_wr.word     = word_q;
          end
        end
        tspm_pkg::REQ_STOP: begin
          if (sel_ok) begin
            status_next   = tspm_pkg::STAT_DONE;
            freed_next    = 1'b1;
            fl_ctrl.push  = go;
            rec_we        = go;
            rec_waddr     = sel_wide[ID_W-1:0];
            rec_wr        = rec_rd;
            rec_wr.in_use = 1'b0;
          end
        end
        tspm_pkg::REQ_TIMEOUT: begin
          if (sel_ok) begin
            status_next    = tspm_pkg::STAT_DONE;
            msg_valid_next = 1'b1;
            msg_dest_next  = rec_rd.owner;
            msg_label_next = rec_rd.label;
            msg_word_next  = rec_rd.word;
            if (!rec_rd.periodic) begin
              freed_next    = 1'b1;
              fl_ctrl.push  = go;
              rec_we        = go;
              rec_waddr     = sel_wide[ID_W-1:0];
              rec_wr        = rec_rd;
              rec_wr.in_use = 1'b0;
            end
          end
        end
        default: status_next = tspm_pkg::STAT_IGNORED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tspm_pkg::S_CLEAR;
      clear_ptr <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tspm_pkg::S_CLEAR) begin
        clear_ptr <= clear_ptr + ID_W'(1);
      end
      if (go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q      <= req_type;
      owner_q    <= owner_module;
      label_q    <= timer_label;
      duration_q <= duration;
      word_q     <= user_word;
      periodic_q <= is_periodic;
      sel_q      <= slot_sel;
    end
    if (go) begin
      status     <= status_next;
      slot_out   <= slot_out_next;
      period_out <= period_next;
      msg_valid  <= msg_valid_next;
      msg_dest   <= msg_dest_next;
      msg_label  <= msg_label_next;
      msg_word   <= msg_word_next;
      slot_freed <= freed_next;
    end
  end

endmodule

// File: src/tspm_checker.sv
// ----------------------------------------------------------------------------
// tspm_checker
// Port-level checks of the timer slot pool manager, bound to the top level.
// ----------------------------------------------------------------------------
module tspm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [5:0]  slot_out,
  input logic [31:0] period_out,
  input logic        msg_valid,
  input logic        slot_freed
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_out))
    else $error("result beat dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted before the first completed");

  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == tspm_pkg::STAT_EMPTY) |->
      !msg_valid && !slot_freed && (slot_out == '0) && (period_out == '0))
    else $error("empty-pool result carries data");

  a_ignored_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == tspm_pkg::STAT_IGNORED) |->
      !msg_valid && !slot_freed && (slot_out == '0))
    else $error("ignored request shows an effect");

  a_msg_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (msg_valid || slot_freed) |-> (status == tspm_pkg::STAT_DONE))
    else $error("message or release without done status");

endmodule

bind timer_slot_pool_manager tspm_checker u_tspm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .slot_out  (slot_out),
  .period_out(period_out),
  .msg_valid (msg_valid),
  .slot_freed(slot_freed)
);
